// ===== hw/rtl/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants for the dictionary run bit decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 4;
    localparam int REP_W        = 2;
    localparam int IDX_W        = 4;
    localparam int LEFT_W       = 4;

    localparam int DICT_ENTRIES = 15;

    localparam logic [LEN_W-1:0]  LIT_LEN    = LEN_W'(9);
    localparam logic [LEN_W-1:0]  RUN_LEN    = LEN_W'(8);
    localparam logic [LEN_W-1:0]  ZERO_LEN   = LEN_W'(2);
    localparam logic [LEFT_W-1:0] BITS_PER_BYTE = LEFT_W'(8);

    typedef enum logic [2:0] {
        CK_NONE,
        CK_LITERAL,
        CK_ZERO,
        CK_RUN,
        CK_END,
        CK_BAD
    } t_code_kind;

    // one finished code, as seen by the sequencer
    typedef struct packed {
        t_code_kind             kind;
        logic [BYTE_W-1:0]      lit;
        logic [REP_W-1:0]       rep;
        logic [IDX_W-1:0]       idx;
    } t_code_event;

    // code gathering state
    typedef struct packed {
        logic [BYTE_W-1:0]      bits;
        logic [LEN_W-1:0]       len;
        logic                   first;
    } t_code_state;

    typedef struct packed {
        logic [BYTE_W-1:0]      out_byte;
        logic                   byte_valid;
        logic                   last_of_run;
        logic                   stream_end;
        logic                   bad_index;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

// ===== hw/rtl/drd_if.sv =====
// ----------------------------------------------------------------------------
// drd_in_if / drd_out_if
// Valid/ready channels for encoded input bytes and decoded output beats.
// ----------------------------------------------------------------------------
interface drd_in_if;
    logic                       valid;
    logic                       ready;
    logic [drd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface drd_out_if;
    logic                       valid;
    logic                       ready;
    logic [drd_pkg::BYTE_W-1:0] out_byte;
    logic                       byte_valid;
    logic                       last_of_run;
    logic                       stream_end;
    logic                       bad_index;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output stream_end, output bad_index,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last_of_run, input stream_end, input bad_index,
                    output ready);
endinterface

// ===== hw/rtl/drd_code_parser.sv =====
// ----------------------------------------------------------------------------
// drd_code_parser
// One-bit step of the prefix code parser: appends a bit to the partial code
// and reports a finished code.
// ----------------------------------------------------------------------------
module drd_code_parser (
    input  drd_pkg::t_code_state i_state,
    input  logic                 i_bit,
    output drd_pkg::t_code_state o_state,
    output drd_pkg::t_code_event o_event
);
    import drd_pkg::*;

    logic [LEN_W-1:0]  w_len;
    logic              w_first;
    logic [BYTE_W-1:0] w_bits;

    always_comb begin
        w_len   = i_state.len + LEN_W'(1);
        w_first = (i_state.len == '0) ? i_bit : i_state.first;
        w_bits  = {i_state.bits[BYTE_W-2:0], i_bit};

        o_event.kind = CK_NONE;
        o_event.lit  = w_bits;
        o_event.rep  = w_bits[IDX_W +: REP_W];
        o_event.idx  = w_bits[IDX_W-1:0];

        if (!w_first && w_len == LIT_LEN) begin
            o_event.kind = CK_LITERAL;
        end else if (w_first && w_len == ZERO_LEN && !i_bit) begin
            o_event.kind = CK_ZERO;
        end else if (w_first && w_len == RUN_LEN) begin
            if (w_bits[IDX_W-1:0] != '0) begin
                o_event.kind = CK_RUN;
            end else if (w_bits[IDX_W +: REP_W] == '0) begin
                o_event.kind = CK_END;
            end else begin
                o_event.kind = CK_BAD;
            end
        end

        if (o_event.kind == CK_NONE) begin
            o_state.bits  = w_bits;
            o_state.len   = w_len;
            o_state.first = w_first;
        end else begin
            o_state.bits  = '0;
            o_state.len   = '0;
            o_state.first = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/dictionary_run_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// dictionary_run_bit_decoder
// Loads a 15-entry dictionary, then decodes literal, zero, run and end codes.
// ----------------------------------------------------------------------------
// Takes one byte per input beat. The first 15 bytes after reset fill the
// dictionary, with no output. Every later byte is taken in and is then
// shifted through the code parser one bit per cycle unless held, MSB first.
// A dictionary run emits each additional copy from ST_RUN, and ST_FLUSH
// hands over the last output beat when the byte caused any; the end code
// cuts its byte short. A new input byte is taken only once the previous one
// is done. Output stalls hold the bit shifter. The final beat caused by an
// input byte carries last_of_run. After the end code the block reports it
// once and then accepts and drops input until reset.
module dictionary_run_bit_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    drd_in_if.sink           i_in,
    drd_out_if.source        o_out
);
    import drd_pkg::*;

    t_state              r_state, n_state;
    logic [BYTE_W-1:0]   r_dict [DICT_ENTRIES];
    logic [IDX_W-1:0]    r_dcnt, n_dcnt;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [LEFT_W-1:0]   r_left, n_left;
    t_code_state         r_code, n_code;
    logic                r_fin, n_fin;
    logic [REP_W-1:0]    r_run_left, n_run_left;
    t_out_beat           r_pend, n_pend;
    logic                r_pend_valid, n_pend_valid;
    t_out_beat           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    t_code_state         w_code_nx;
    t_code_event         w_ev;
    logic                w_accept;
    logic                w_out_free;
    logic                w_gen;
    logic                w_dict_we;
    logic                w_dict_rd;

    drd_code_parser u_parser (
        .i_state (r_code),
        .i_bit   (r_shift[BYTE_W-1]),
        .o_state (w_code_nx),
        .o_event (w_ev)
    );

    assign i_in.ready        = (r_state == ST_IDLE);
    assign w_accept          = i_in.valid && (r_state == ST_IDLE);
    assign w_out_free        = !r_out_valid || o_out.ready;
    assign w_gen             = (w_ev.kind != CK_NONE);

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.byte_valid  = r_out.byte_valid;
    assign o_out.last_of_run = r_out.last_of_run;
    assign o_out.stream_end  = r_out.stream_end;
    assign o_out.bad_index   = r_out.bad_index;

    always_comb begin
        n_state      = r_state;
        n_dcnt       = r_dcnt;
        n_shift      = r_shift;
        n_left       = r_left;
        n_code       = r_code;
        n_fin        = r_fin;
        n_run_left   = r_run_left;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_out.ready;
        w_dict_we    = 1'b0;
        w_dict_rd    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && !r_fin) begin
                    if (r_dcnt < IDX_W'(DICT_ENTRIES)) begin
                        w_dict_we = 1'b1;
                        n_dcnt    = r_dcnt + IDX_W'(1);
                    end else begin
                        n_shift = i_in.in_byte;
                        n_left  = BITS_PER_BYTE;
                        n_state = ST_BITS;
                    end
                end
            end

            ST_BITS: begin
                // hold the bit while a finished result cannot be staged
                if (!(w_gen && r_pend_valid && !w_out_free)) begin
                    n_code  = w_code_nx;
                    n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                    n_left  = r_left - LEFT_W'(1);
                    if (w_gen) begin
                        if (r_pend_valid) begin
                            n_out             = r_pend;
                            n_out.last_of_run = 1'b0;
                            n_out_valid       = 1'b1;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = '0;
                        case (w_ev.kind)
                            CK_LITERAL: begin
                                n_pend.out_byte   = w_ev.lit;
                                n_pend.byte_valid = 1'b1;
                            end
                            CK_ZERO: begin
                                n_pend.byte_valid = 1'b1;
                            end
                            CK_RUN: begin
                                // byte comes from the dictionary read below
                                n_pend.byte_valid = 1'b1;
                                w_dict_rd         = 1'b1;
                            end
                            CK_END: begin
                                n_pend.stream_end = 1'b1;
                                n_fin             = 1'b1;
                            end
                            CK_BAD: begin
                                n_pend.bad_index = 1'b1;
                            end
                            default: begin
                                n_pend_valid = r_pend_valid;
                            end
                        endcase
                    end

                    if (w_ev.kind == CK_RUN && w_ev.rep != '0) begin
                        n_run_left = w_ev.rep;
                        n_state    = ST_RUN;
                    end else if (n_left == '0 || w_ev.kind == CK_END) begin
                        n_state = (w_gen || r_pend_valid) ? ST_FLUSH : ST_IDLE;
                    end
                end
            end

            ST_RUN: begin
                if (w_out_free) begin
                    n_out             = r_pend;
                    n_out.last_of_run = 1'b0;
                    n_out_valid       = 1'b1;
                    n_run_left        = r_run_left - REP_W'(1);
                    if (r_run_left == REP_W'(1)) begin
                        n_state = (r_left == '0) ? ST_FLUSH : ST_BITS;
                    end
                end
            end

            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out             = r_pend;
                    n_out.last_of_run = 1'b1;
                    n_out_valid       = 1'b1;
                    n_pend_valid      = 1'b0;
                    n_state           = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt       <= '0;
            r_code       <= '0;
            r_fin        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_left       <= '0;
            r_run_left   <= '0;
        end else begin
            r_dcnt       <= n_dcnt;
            r_code       <= n_code;
            r_fin        <= n_fin;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_left       <= n_left;
            r_run_left   <= n_run_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_out   <= n_out;
        if (w_dict_rd) begin
            r_pend <= '{out_byte:    r_dict[w_ev.idx - IDX_W'(1)],
                        byte_valid:  n_pend.byte_valid,
                        last_of_run: n_pend.last_of_run,
                        stream_end:  n_pend.stream_end,
                        bad_index:   n_pend.bad_index};
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dict_we) begin
            r_dict[r_dcnt] <= i_in.in_byte;
        end
    end

endmodule
